>>> rtl/pqnp_pkg.sv
package pqnp_pkg;

	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned COLOR_W    = 3 * CHAN_W;
	localparam int unsigned PAIR_W     = 2 * COLOR_W;
	localparam int unsigned PAIR_COUNT = 8;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned LEAVES     = 16;
	localparam int unsigned DIST_W     = 10;
	localparam int unsigned BYTE_W     = 2 * IDX_W;
	localparam int unsigned DEF_PALETTE_SIZE = 16;

	// Winning index of one pixel, with its row mark, handed to the pair packer.
	typedef struct packed {
		logic             row_start;
		logic [IDX_W-1:0] idx;
	} pix_t;

endpackage

>>> rtl/pqnp_dist.sv
module pqnp_dist (
	input  logic [pqnp_pkg::CHAN_W-1:0]  red,
	input  logic [pqnp_pkg::CHAN_W-1:0]  green,
	input  logic [pqnp_pkg::CHAN_W-1:0]  blue,
	input  logic [pqnp_pkg::COLOR_W-1:0] color,
	output logic [pqnp_pkg::DIST_W-1:0]  distance
);

	logic [pqnp_pkg::CHAN_W-1:0] cr, cg, cb;
	logic [pqnp_pkg::CHAN_W-1:0] dr, dg, db;

	assign cr = color[3*pqnp_pkg::CHAN_W-1:2*pqnp_pkg::CHAN_W];
	assign cg = color[2*pqnp_pkg::CHAN_W-1:pqnp_pkg::CHAN_W];
	assign cb = color[pqnp_pkg::CHAN_W-1:0];

	assign dr = (cr > red)   ? cr - red   : red - cr;
	assign dg = (cg > green) ? cg - green : green - cg;
	assign db = (cb > blue)  ? cb - blue  : blue - cb;

	assign distance = pqnp_pkg::DIST_W'(dr) + pqnp_pkg::DIST_W'(dg) + pqnp_pkg::DIST_W'(db);

endmodule

>>> rtl/pqnp_argmin.sv
module pqnp_argmin #(
	parameter int unsigned N = pqnp_pkg::DEF_PALETTE_SIZE
) (
	input  logic [pqnp_pkg::DIST_W-1:0] distance [N],
	output logic [pqnp_pkg::IDX_W-1:0]  idx
);

	localparam int unsigned NODES = 2 * pqnp_pkg::LEAVES - 1;
	localparam int unsigned FIRST_LEAF = pqnp_pkg::LEAVES - 1;

	// Heap-ordered comparison tree: node n has children 2n+1 and 2n+2.
	logic [pqnp_pkg::DIST_W-1:0] node_dist [NODES];
	logic [pqnp_pkg::IDX_W-1:0]  node_idx  [NODES];

	genvar j, n;
	generate
		for (j = 0; j < pqnp_pkg::LEAVES; j++) begin : g_leaf
			// Unused leaves carry a distance no real entry can reach.
			if (j < N) begin : g_used
				assign node_dist[FIRST_LEAF + j] = distance[j];
			end else begin : g_pad
				assign node_dist[FIRST_LEAF + j] = '1;
			end
			assign node_idx[FIRST_LEAF + j] = pqnp_pkg::IDX_W'(j);
		end
		for (n = 0; n < FIRST_LEAF; n++) begin : g_node
			// The left child always holds the lower indexes, so it wins ties.
			logic take_left;
			assign take_left = node_dist[2*n+1] <= node_dist[2*n+2];
			assign node_dist[n] = take_left ? node_dist[2*n+1] : node_dist[2*n+2];
			assign node_idx[n]  = take_left ? node_idx[2*n+1]  : node_idx[2*n+2];
		end
	endgenerate

	assign idx = node_idx[0];

endmodule

>>> rtl/pqnp_pack.sv
module pqnp_pack (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pix_valid,
	input  pqnp_pkg::pix_t               pix,
	output logic                         pix_take,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pqnp_pkg::BYTE_W-1:0]  packed_byte
);

	logic                        phase_q;
	logic [pqnp_pkg::IDX_W-1:0]  held_q;
	logic [pqnp_pkg::BYTE_W-1:0] byte_q;
	logic                        valid_q;
	logic                        odd;

	// A row mark restarts pairing, dropping any held even pixel.
	assign odd      = phase_q && !pix.row_start;
	assign pix_take = pix_valid && (!odd || !valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			held_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pix_take) begin
				if (odd) begin
					phase_q <= 1'b0;
				end else begin
					phase_q <= 1'b1;
					held_q  <= pix.idx;
				end
			end
			if (pix_take && odd) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_take && odd) begin
			byte_q <= {held_q, pix.idx};
		end
	end

	assign out_valid   = valid_q;
	assign packed_byte = byte_q;

endmodule

>>> rtl/palette_quantize_nibble_pack.sv
// Maps each RGB888 pixel to the nearest of PALETTE_SIZE palette colors by
// Manhattan distance (lowest index on a tie) and packs each even/odd pixel
// pair of a row into one byte, even index in the high nibble. A pixel with
// row_start set begins a new pair, and an unpaired last pixel of a row is
// dropped. One pixel is accepted per clock while the input is not stalled; a
// packed byte passes through the input register, the distance register and
// the index register before reaching the output register. Only a full output
// register that is not being read stalls the input, and then only for an odd
// pixel arriving at the packer. The palette is written through the cfg port,
// two colors per register, lower entry in bits 23:0; indexes above 7 are
// ignored. Write the palette only while no pixels are in flight.
module palette_quantize_nibble_pack #(
	parameter int unsigned PALETTE_SIZE = pqnp_pkg::DEF_PALETTE_SIZE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pqnp_pkg::CHAN_W-1:0]     red,
	input  logic [pqnp_pkg::CHAN_W-1:0]     green,
	input  logic [pqnp_pkg::CHAN_W-1:0]     blue,
	input  logic                            row_start,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pqnp_pkg::BYTE_W-1:0]     packed_byte,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pqnp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pqnp_pkg::PAIR_W-1:0]     cfg_data
);

	logic [pqnp_pkg::PAIR_W-1:0] palette_q [pqnp_pkg::PAIR_COUNT];

	logic                        valid_s1, valid_s2, valid_s3;
	logic                        ready_s1, ready_s2, ready_s3;
	logic [pqnp_pkg::CHAN_W-1:0] red_s1, green_s1, blue_s1;
	logic                        row_start_s1, row_start_s2;
	logic [pqnp_pkg::DIST_W-1:0] dist_c  [PALETTE_SIZE];
	logic [pqnp_pkg::DIST_W-1:0] dist_s2 [PALETTE_SIZE];
	logic [pqnp_pkg::IDX_W-1:0]  idx_c;
	pqnp_pkg::pix_t              pix_s3;
	logic                        pix_take;

	// Palette registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < pqnp_pkg::PAIR_COUNT; k++) begin
				palette_q[k] <= '0;
			end
		end else if (cfg_valid && cfg_index < pqnp_pkg::CFG_IDX_W'(pqnp_pkg::PAIR_COUNT)) begin
			palette_q[cfg_index[$clog2(pqnp_pkg::PAIR_COUNT)-1:0]] <= cfg_data;
		end
	end

	// Stage ready chain: a stage can load when empty or when it moves on.
	assign ready_s3 = !valid_s3 || pix_take;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			red_s1       <= red;
			green_s1     <= green;
			blue_s1      <= blue;
			row_start_s1 <= row_start;
		end
		if (ready_s2) begin
			dist_s2      <= dist_c;
			row_start_s2 <= row_start_s1;
		end
		if (ready_s3) begin
			pix_s3.idx       <= idx_c;
			pix_s3.row_start <= row_start_s2;
		end
	end

	genvar i;
	generate
		for (i = 0; i < PALETTE_SIZE; i++) begin : g_dist
			pqnp_dist u_dist (
				.red      (red_s1),
				.green    (green_s1),
				.blue     (blue_s1),
				.color    (palette_q[i/2][(i%2)*pqnp_pkg::COLOR_W +: pqnp_pkg::COLOR_W]),
				.distance (dist_c[i])
			);
		end
	endgenerate

	pqnp_argmin #(
		.N (PALETTE_SIZE)
	) u_argmin (
		.distance (dist_s2),
		.idx      (idx_c)
	);

	pqnp_pack u_pack (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (valid_s3),
		.pix         (pix_s3),
		.pix_take    (pix_take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packed_byte (packed_byte)
	);

	// The input can only stall when the packer holds an odd pixel against a full output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s3 && out_valid && !out_ready))
		else $error("input stalled without a blocked output");

	// A stalled distance stage keeps its contents.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !ready_s3) |=> (valid_s2 && $stable(row_start_s2)))
		else $error("distance stage lost an item while stalled");

	// A new byte is loaded only when an odd pixel is taken by the packer.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) ##1 out_valid |-> $past(valid_s3 && pix_take))
		else $error("result appeared without a paired pixel");

endmodule
